// ----- rtl/iisq_pkg.sv -----
// shared widths, register indexes and stage types of the integral image block
package iisq_pkg;

  // field widths
  localparam int PIX_W = 8;
  localparam int SUM_W = 32;
  localparam int SQ_W  = 40;
  localparam int CFG_W = 13;

  // default frame size bounds
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // per-item data handed from the row front end to the accumulate stage
  typedef struct packed {
    logic [SUM_W-1:0] run_sum;
    logic [SQ_W-1:0]  run_sq;
    logic             first_row;
    logic             frame_end;
  } iisq_item_t;

endpackage

// ----- rtl/iisq_line_store.sv -----
// single-port-read, single-port-write line store with registered read data
module iisq_line_store #(
  parameter int DEPTH  = iisq_pkg::MAX_WIDTH_DEF,
  parameter int DATA_W = iisq_pkg::SUM_W + iisq_pkg::SQ_W
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/iisq_row_ctrl.sv -----
// column and row counters and the running row sums
module iisq_row_ctrl #(
  parameter int MAX_WIDTH  = iisq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iisq_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [iisq_pkg::PIX_W-1:0]   pixel,
  input  logic [iisq_pkg::CFG_W-1:0]   image_width,
  input  logic [iisq_pkg::CFG_W-1:0]   image_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output iisq_pkg::iisq_item_t         item
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW   = (CW > RW) ? CW + 1 : RW + 1;
  localparam int CMPW = (MW > iisq_pkg::CFG_W) ? MW : iisq_pkg::CFG_W + 1;
  localparam int SQP_W = 2 * iisq_pkg::PIX_W;

  logic [CW-1:0]             col_r, col_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [iisq_pkg::SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [iisq_pkg::SQ_W-1:0]  run_sq_r, run_sq_nxt;

  logic [SQP_W-1:0]          pix_sq;
  logic [iisq_pkg::SUM_W-1:0] sum_add;
  logic [iisq_pkg::SQ_W-1:0]  sq_add;
  logic [CMPW-1:0]           w_eff, h_eff;
  logic                      row_end, frame_end;

  // effective frame size: zero counts as one, clamp to the bound
  always_comb begin
    if (image_width == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = CMPW'(1);
    end else if (CMPW'(image_height) > CMPW'(MAX_HEIGHT)) begin
      h_eff = CMPW'(MAX_HEIGHT);
    end else begin
      h_eff = CMPW'(image_height);
    end
  end

  // running row totals including this pixel
  assign pix_sq  = SQP_W'(pixel) * SQP_W'(pixel);
  assign sum_add = run_sum_r + iisq_pkg::SUM_W'(pixel);
  assign sq_add  = run_sq_r + iisq_pkg::SQ_W'(pix_sq);

  // end of row and end of frame
  assign row_end   = (CMPW'(col_r) + CMPW'(1)) >= w_eff;
  assign frame_end = row_end && ((CMPW'(row_r) + CMPW'(1)) >= h_eff);

  // counter and accumulator update
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    run_sum_nxt = run_sum_r;
    run_sq_nxt  = run_sq_r;
    if (accept) begin
      if (row_end) begin
        col_nxt     = '0;
        run_sum_nxt = '0;
        run_sq_nxt  = '0;
        row_nxt     = frame_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt     = col_r + CW'(1);
        run_sum_nxt = sum_add;
        run_sq_nxt  = sq_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      run_sum_r <= '0;
      run_sq_r  <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      run_sum_r <= run_sum_nxt;
      run_sq_r  <= run_sq_nxt;
    end
  end

  // item data for the accumulate stage
  assign col            = col_r;
  assign item.run_sum   = sum_add;
  assign item.run_sq    = sq_add;
  assign item.first_row = (row_r == '0);
  assign item.frame_end = frame_end;

endmodule

// ----- rtl/integral_and_squared_integral_image.sv -----
// top level of the integral image and squared integral image block
// Takes one pixel per clock in raster order while in_ready is high and gives one result
// per pixel through stage 1 and the output register. The rate is set by the line store:
// each pixel reads its column's previous-row totals at acceptance and writes the new
// totals back as it leaves stage 1 through a single write port, with the written value
// forwarded when the next pixel reads the same column (a frame one pixel wide). The
// line store is never cleared; the first row of a frame ignores the data it reads.
module integral_and_squared_integral_image #(
  parameter int MAX_WIDTH  = iisq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iisq_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [iisq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iisq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iisq_pkg::PIX_W-1:0]     in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [iisq_pkg::SUM_W-1:0]     out_area_sum,
  output logic [iisq_pkg::SQ_W-1:0]      out_area_square_sum,
  output logic                           out_frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = iisq_pkg::SUM_W + iisq_pkg::SQ_W;

  logic [iisq_pkg::CFG_W-1:0] width_r, height_r;

  logic                 accept, s1_move;
  logic [CW-1:0]        col;
  iisq_pkg::iisq_item_t item;

  logic                 s1_valid_r, s1_valid_nxt;
  iisq_pkg::iisq_item_t s1_item_r;
  logic [CW-1:0]        s1_col_r;
  logic                 fwd_r;
  logic [LW-1:0]        fwd_data_r;

  logic [LW-1:0]              rd_data, prior, s1_total;
  logic [iisq_pkg::SUM_W-1:0] s1_sum;
  logic [iisq_pkg::SQ_W-1:0]  s1_sq;

  logic out_valid_r;
  logic [iisq_pkg::SUM_W-1:0] out_sum_r;
  logic [iisq_pkg::SQ_W-1:0]  out_sq_r;
  logic out_frame_end_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iisq_pkg::WIDTH_RESET;
      height_r <= iisq_pkg::HEIGHT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        iisq_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        iisq_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves when the output register is free or being taken
  assign s1_move  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  iisq_row_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_row_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pixel        (in_pixel),
    .image_width  (width_r),
    .image_height (height_r),
    .col          (col),
    .item         (item)
  );

  iisq_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_valid_r && s1_move),
    .wr_addr (s1_col_r),
    .wr_data (s1_total)
  );

  // accumulate stage: row total plus previous row's totals
  assign prior    = fwd_r ? fwd_data_r : rd_data;
  assign s1_sum   = s1_item_r.run_sum
                  + (s1_item_r.first_row ? '0 : prior[LW-1:iisq_pkg::SQ_W]);
  assign s1_sq    = s1_item_r.run_sq
                  + (s1_item_r.first_row ? '0 : prior[iisq_pkg::SQ_W-1:0]);
  assign s1_total = {s1_sum, s1_sq};

  // stage 1 occupancy
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // stage 1 payload and same-column forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= item;
      s1_col_r   <= col;
      fwd_r      <= s1_valid_r && (s1_col_r == col);
      fwd_data_r <= s1_total;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_sum_r       <= s1_sum;
      out_sq_r        <= s1_sq;
      out_frame_end_r <= s1_item_r.frame_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_area_sum        = out_sum_r;
  assign out_area_square_sum = out_sq_r;
  assign out_frame_end       = out_frame_end_r;

  // input stalls only behind a full stage 1 and a held output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked pipeline");

  // a new result comes only from a filled stage 1
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a stage 1 item");

  // an accepted item always lands in stage 1
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost before stage 1");

endmodule
